### rtl/ppn_pkg.sv
// Shared types and constants for the point to polyline nearest block.
`timescale 1ns / 1ps
package ppn_pkg;
    localparam int COORD_BITS_DEF   = 24;
    localparam int MAX_VERTICES_DEF = 4096;
    localparam int SEG_BITS         = 12;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SUM, S_CLASS, S_DIV, S_NEXT, S_DIST, S_DSUM, S_SQRT, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_INIT, OP_SEG, OP_REPORT
    } t_op;
endpackage

### rtl/ppn_if.sv
// Valid/ready channel interface.
`timescale 1ns / 1ps
interface ppn_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/ppn_queue.sv
// Two-entry queue between the front classifier and the back engine.
`timescale 1ns / 1ps
module ppn_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

### rtl/ppn_back.sv
// Segment engine: projection, iterative divide, best tracking, iterative root.
`timescale 1ns / 1ps
module ppn_back
    import ppn_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command: op (init, segment, report), found, a, b, q, index
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic                 i_found,
    input  logic [3*CB-1:0]      i_a,
    input  logic [3*CB-1:0]      i_b,
    input  logic [3*CB-1:0]      i_q,
    input  logic [SEG_BITS-1:0]  i_idx,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CB+1+3*CB+SEG_BITS:0] o_data
);
    localparam int DW = CB + 1;        // difference width
    localparam int PW = 2 * DW + 2;    // sum of three squares
    localparam int NW = PW + DW + 2;   // divide numerator
    localparam int RW = CB + 1;        // root width
    localparam int LW = PW / 2;        // low half of the dot product
    localparam int DS = 3;             // numerator setup cycles
    localparam int CW = $clog2(NW + DS + 1);

    t_state r_st, n_st;
    logic signed [DW-1:0] r_ab [3], r_as [3];
    logic signed [CB-1:0] r_a [3], r_b [3], r_q [3], r_p [3];
    logic signed [2*DW-1:0] r_pd [3], r_pl [3];
    logic signed [PW-1:0]  r_dot;
    logic [PW-1:0]         r_len, r_d2;
    logic [PW:0]           r_best;
    logic signed [CB-1:0]  r_bp [3];
    logic [SEG_BITS-1:0]   r_idx, r_bidx;
    logic [1:0]            r_k;
    logic [NW-1:0]         r_num, r_quo;
    logic [NW:0]           r_rem;
    logic [CW-1:0]         r_cnt;
    logic [RW-1:0]         r_root;
    logic                  r_found, r_ov;
    logic [CB+1+3*CB+SEG_BITS:0] r_out;

    logic [DW-1:0]  w_mag;
    logic [NW:0]    w_trial;
    logic [RW-1:0]  w_cand;
    logic [2*RW-1:0] w_sq;
    logic signed [DW:0] w_pk;

    // only a report has to wait for the held result
    assign o_ready = (r_st == S_IDLE) && !(r_ov && i_op == OP_REPORT);
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign w_mag   = r_ab[r_k][DW-1] ? DW'(-r_ab[r_k]) : r_ab[r_k];
    assign w_trial = {r_rem[NW-1:0], r_num[NW-1]};
    assign w_cand  = r_root | (RW'(1) << r_cnt);
    assign w_sq    = w_cand * w_cand;
    assign w_pk    = r_ab[r_k][DW-1] ? (DW+1)'(r_a[r_k]) - (DW+1)'(r_quo)
                                     : (DW+1)'(r_a[r_k]) + (DW+1)'(r_quo);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_valid && o_ready) begin
                n_st = (i_op == OP_SEG) ? S_MUL : (i_op == OP_REPORT) ? S_SQRT : S_IDLE;
            end
            S_MUL:   n_st = S_SUM;
            S_SUM:   n_st = S_CLASS;
            S_CLASS: n_st = (r_len == '0 || r_dot <= 0 || $signed({1'b0, r_len}) <= r_dot)
                            ? S_DIST : S_DIV;
            S_DIV:   if (r_cnt == CW'(NW + DS)) n_st = S_NEXT;
            S_NEXT:  n_st = (r_k == 2'd2) ? S_DIST : S_DIV;
            S_DIST:  n_st = S_DSUM;
            S_DSUM:  n_st = S_IDLE;
            S_SQRT:  if (r_cnt == '0) n_st = S_OUT;
            S_OUT:   n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_best <= '1;
            r_cnt <= '0;
            r_k <= '0;
            for (int k = 0; k < 3; k++) r_bp[k] <= '0;
            r_bidx <= '0;
        end else begin
            r_st <= n_st;
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid && o_ready) begin
                    r_found <= i_found; r_idx <= i_idx;
                    for (int k = 0; k < 3; k++) begin
                        r_a[k] <= i_a[k*CB +: CB];
                        r_b[k] <= i_b[k*CB +: CB];
                        r_q[k] <= i_q[k*CB +: CB];
                        r_ab[k] <= DW'(signed'(i_b[k*CB +: CB])) - DW'(signed'(i_a[k*CB +: CB]));
                        r_as[k] <= DW'(signed'(i_q[k*CB +: CB])) - DW'(signed'(i_a[k*CB +: CB]));
                    end
                    if (i_op == OP_INIT) begin
                        r_best <= '1;
                        r_bidx <= '0;
                        for (int k = 0; k < 3; k++) r_bp[k] <= '0;
                    end
                    r_cnt <= CW'(RW - 1);
                    r_root <= '0;
                end
                S_MUL: for (int k = 0; k < 3; k++) begin
                    r_pd[k] <= r_ab[k] * r_as[k];
                    r_pl[k] <= r_ab[k] * r_ab[k];
                end
                S_SUM: begin
                    r_dot <= PW'(r_pd[0]) + PW'(r_pd[1]) + PW'(r_pd[2]);
                    r_len <= PW'(r_pl[0]) + PW'(r_pl[1]) + PW'(r_pl[2]);
                end
                S_CLASS: begin
                    for (int k = 0; k < 3; k++) begin
                        r_p[k] <= (r_len == '0 || r_dot <= 0) ? r_a[k] : r_b[k];
                    end
                    r_k <= '0;
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_quo <= '0;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        // numerator 2*|ab|*dot + len, dot multiplied in two halves
                        r_num <= NW'(w_mag * r_dot[LW-1:0]);
                        r_cnt <= r_cnt + 1'b1;
                    end else if (r_cnt == CW'(1)) begin
                        r_num <= r_num + (NW'(w_mag * r_dot[PW-1:LW]) << LW);
                        r_cnt <= r_cnt + 1'b1;
                    end else if (r_cnt == CW'(2)) begin
                        r_num <= (r_num << 1) + NW'(r_len);
                        r_cnt <= r_cnt + 1'b1;
                    end else if (r_cnt != CW'(NW + DS)) begin
                        r_num <= r_num << 1;
                        if (w_trial >= {r_len, 1'b0}) begin
                            r_rem <= w_trial - {r_len, 1'b0};
                            r_quo <= {r_quo[NW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_trial;
                            r_quo <= {r_quo[NW-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_NEXT: begin
                    r_p[r_k] <= CB'(w_pk);
                    r_k <= r_k + 1'b1;
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_quo <= '0;
                end
                S_DIST: for (int k = 0; k < 3; k++) begin
                    r_pl[k] <= ((DW)'(r_p[k]) - DW'(r_q[k])) * ((DW)'(r_p[k]) - DW'(r_q[k]));
                end
                S_DSUM: begin
                    if ({1'b0, PW'(r_pl[0]) + PW'(r_pl[1]) + PW'(r_pl[2])} < r_best) begin
                        r_best <= {1'b0, PW'(r_pl[0]) + PW'(r_pl[1]) + PW'(r_pl[2])};
                        for (int k = 0; k < 3; k++) r_bp[k] <= r_p[k];
                        r_bidx <= r_idx;
                    end
                end
                S_SQRT: begin
                    if ((PW+1)'(w_sq) <= r_best && 2*RW <= PW + 1) r_root <= w_cand;
                    else if (2*RW > PW + 1 && w_sq <= (2*RW)'(r_best)) r_root <= w_cand;
                    if (r_cnt != '0) r_cnt <= r_cnt - 1'b1;
                end
                S_OUT: begin
                    r_ov <= 1'b1;
                    if (r_found) begin
                        r_out <= {1'b1, r_root, r_bp[2], r_bp[1], r_bp[0], r_bidx};
                    end else begin
                        r_out <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/ppn_front.sv
// Front end: holds query and previous vertex, counts vertices, issues commands.
`timescale 1ns / 1ps
module ppn_front
    import ppn_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int MAXV = MAX_VERTICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [3*CB-1:0]     i_q,
    input  logic [3*CB-1:0]     i_v,
    input  logic                i_first,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2+1+9*CB+SEG_BITS-1:0] o_cmd
);
    localparam int VW = $clog2(MAXV + 1);
    logic [3*CB-1:0] r_q, r_prev;
    logic [VW-1:0]   r_cnt;
    logic            r_pend;       // report still to issue
    logic            r_found;
    logic [1:0]      w_op;
    logic [VW-1:0]   w_cnt;
    logic [3*CB-1:0] w_q;
    logic            w_cmd;

    assign w_q   = i_first ? i_q : r_q;
    assign w_cnt = i_first ? '0 : r_cnt;
    assign w_cmd = (w_cnt == '0) || (w_cnt < VW'(MAXV));
    assign w_op  = (w_cnt == '0) ? OP_INIT : OP_SEG;
    assign o_ready = !r_pend && i_ready;
    assign o_valid = r_pend || (i_valid && w_cmd);
    assign o_cmd = r_pend
        ? {OP_REPORT, r_found, {(9*CB){1'b0}}, {SEG_BITS{1'b0}}}
        : {w_op, 1'b0, r_prev, i_v, w_q, SEG_BITS'(w_cnt - 1'b1)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0; r_prev <= '0; r_cnt <= '0;
            r_pend <= 1'b0; r_found <= 1'b0;
        end else if (r_pend) begin
            if (i_ready) r_pend <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_q <= w_q;
            if (w_cmd) r_prev <= i_v;
            if (w_cmd) r_cnt <= w_cnt + 1'b1;
            else r_cnt <= w_cnt;
            if (i_last) begin
                r_pend  <= 1'b1;
                r_found <= (w_cnt != '0);
                r_cnt   <= '0;
            end
        end
    end
endmodule

### rtl/point_to_polyline_nearest.sv
// Nearest point on a 3D polyline to a query point, one vertex per item.
// A segment whose projection lands inside it is paced by three bit-serial divides;
// a clamped segment skips them. The result follows the last segment through the
// bit-serial square root; a two-entry queue lets the front keep accepting.
// Synchronous active-low reset clears counts, best distance and all handshakes.
`timescale 1ns / 1ps
module point_to_polyline_nearest
    import ppn_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ppn_if.sink   i_in,
    ppn_if.source o_out
);
    localparam int CB = COORD_BITS;
    localparam int CMDW = 2 + 1 + 9 * CB + SEG_BITS;
    logic f_valid, f_ready, q_valid, q_ready;
    logic [CMDW-1:0] f_cmd, q_cmd;

    // input data: {last, first, vz, vy, vx, qz, qy, qx}
    ppn_front #(.CB(CB), .MAXV(MAX_VERTICES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_q(i_in.data[3*CB-1:0]), .i_v(i_in.data[6*CB-1:3*CB]),
        .i_first(i_in.data[6*CB]), .i_last(i_in.data[6*CB+1]),
        .o_valid(f_valid), .i_ready(f_ready), .o_cmd(f_cmd)
    );

    ppn_queue #(.W(CMDW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_cmd)
    );

    ppn_back #(.CB(CB)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready),
        .i_op(q_cmd[CMDW-1 -: 2]), .i_found(q_cmd[CMDW-3]),
        .i_a(q_cmd[SEG_BITS+9*CB-1 -: 3*CB]), .i_b(q_cmd[SEG_BITS+6*CB-1 -: 3*CB]),
        .i_q(q_cmd[SEG_BITS+3*CB-1 -: 3*CB]), .i_idx(q_cmd[SEG_BITS-1:0]),
        .o_valid(o_out.valid), .i_ready(o_out.ready), .o_data(o_out.data)
    );
endmodule

### bench/point_to_polyline_nearest_tb.sv
// Self-checking bench for point_to_polyline_nearest: random polylines, stalls, nearest-point model.
`timescale 1ns / 1ps
module point_to_polyline_nearest_tb
    import ppn_pkg::*;
();

    localparam int CB = 24;
    localparam int MAXV = 64;
    localparam int RAND_ITEMS = 1680;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int LONG_HOLD = 3000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic last, first;
        logic signed [CB-1:0] vz, vy, vx;
        logic signed [CB-1:0] qz, qy, qx;
    } vertex_item_t;

    typedef struct packed {
        logic          found;
        logic [CB:0]   distance;
        logic signed [CB-1:0] nz, ny, nx;
        logic [SEG_BITS-1:0] seg;
    } nearest_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ppn_if #(.W($bits(vertex_item_t))) in_ch ();
    ppn_if #(.W($bits(nearest_t))) out_ch ();

    point_to_polyline_nearest #(.MAX_VERTICES(MAXV)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #4 i_clk = ~i_clk;

    vertex_item_t pending[$];
    nearest_t     nearest_q[$];
    int  errors = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    bit  hold_out = 0;
    longint cycles = 0;

    // model state
    longint      m_query[3];
    longint      m_prev[3];
    int          m_count;
    logic [127:0] m_best_d2;
    longint      m_best_pt[3];
    int          m_best_seg;

    task automatic model_reset();
        for (int k = 0; k < 3; k++) begin
            m_query[k] = 0;
            m_prev[k] = 0;
            m_best_pt[k] = 0;
        end
        m_count = 0;
        m_best_d2 = '1;
        m_best_seg = 0;
    endtask

    function automatic longint unsigned floor_sqrt(logic [127:0] n);
        logic [63:0] res;
        logic [63:0] cand;
        res = 0;
        for (int i = 63; i >= 0; i--) begin
            cand = res | (64'd1 << i);
            if (n >= ({64'd0, cand} * {64'd0, cand}))
                res = cand;
        end
        return res;
    endfunction

    task automatic eval_segment(longint b[3], int index);
        longint ab[3];
        longint p[3];
        longint dot, len2, d2, q, mag;
        logic [127:0] num, den;
        dot = 0;
        len2 = 0;
        d2 = 0;
        for (int k = 0; k < 3; k++) begin
            ab[k] = b[k] - m_prev[k];
            dot += ab[k] * (m_query[k] - m_prev[k]);
            len2 += ab[k] * ab[k];
        end
        if (len2 == 0 || dot <= 0) begin
            for (int k = 0; k < 3; k++) p[k] = m_prev[k];
        end else if (dot >= len2) begin
            for (int k = 0; k < 3; k++) p[k] = b[k];
        end else begin
            den = 128'(len2) << 1;
            for (int k = 0; k < 3; k++) begin
                mag = ab[k] < 0 ? -ab[k] : ab[k];
                num = ((128'(mag) * 128'(dot)) << 1) + 128'(len2);
                q = longint'(num / den);
                p[k] = m_prev[k] + (ab[k] < 0 ? -q : q);
            end
        end
        for (int k = 0; k < 3; k++) d2 += (p[k] - m_query[k]) * (p[k] - m_query[k]);
        if (128'(d2) < m_best_d2) begin
            m_best_d2 = 128'(d2);
            for (int k = 0; k < 3; k++) m_best_pt[k] = p[k];
            m_best_seg = index;
        end
    endtask

    task automatic predict_nearest(vertex_item_t it);
        longint v[3];
        nearest_t r;
        v[0] = it.vx;
        v[1] = it.vy;
        v[2] = it.vz;
        if (it.first) begin
            m_query[0] = it.qx;
            m_query[1] = it.qy;
            m_query[2] = it.qz;
            m_count = 0;
        end
        if (m_count == 0) begin
            m_best_d2 = '1;
            for (int k = 0; k < 3; k++) begin
                m_best_pt[k] = 0;
                m_prev[k] = v[k];
            end
            m_best_seg = 0;
            m_count = 1;
        end else if (m_count < MAXV) begin
            eval_segment(v, m_count - 1);
            for (int k = 0; k < 3; k++) m_prev[k] = v[k];
            m_count++;
        end
        if (it.last) begin
            r = '0;
            if (m_count >= 2) begin
                r.found = 1'b1;
                r.distance = (CB + 1)'(floor_sqrt(m_best_d2));
                r.nx = CB'(m_best_pt[0]);
                r.ny = CB'(m_best_pt[1]);
                r.nz = CB'(m_best_pt[2]);
                r.seg = SEG_BITS'(m_best_seg);
            end
            nearest_q.push_back(r);
            m_count = 0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // idle-free stretches, switched on and off at random
    bit burst_mode = 0;
    always @(posedge i_clk) begin
        if ((cycles % 300) == 0) burst_mode <= ($urandom_range(0, 3) == 0);
    end

    // driver
    vertex_item_t cur_item;
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            in_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_nearest(cur_item);
                items_sent++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the offered item
            end else if (in_gap > 0 && !burst_mode) begin
                in_gap <= in_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending.size() > 0) begin
                cur_item = pending.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.data <= cur_item;
                in_gap <= pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    nearest_t got, want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                results_seen++;
                if (nearest_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    errors++;
                end else begin
                    want = nearest_q.pop_front();
                    if (got.found !== want.found)
                        $display("%0t: found exp %0d got %0d", $realtime, want.found, got.found);
                    if (got.distance !== want.distance)
                        $display("%0t: distance exp %0d got %0d", $realtime, want.distance,
                                 got.distance);
                    if (got.nx !== want.nx)
                        $display("%0t: nearest_x exp %0d got %0d", $realtime, want.nx, got.nx);
                    if (got.ny !== want.ny)
                        $display("%0t: nearest_y exp %0d got %0d", $realtime, want.ny, got.ny);
                    if (got.nz !== want.nz)
                        $display("%0t: nearest_z exp %0d got %0d", $realtime, want.nz, got.nz);
                    if (got.seg !== want.seg)
                        $display("%0t: segment_index exp %0d got %0d", $realtime, want.seg, got.seg);
                    if (got !== want) errors++;
                end
            end
            if (hold_out) out_ch.ready <= 1'b0;
            else if (burst_mode) out_ch.ready <= 1'b1;
            else out_ch.ready <= ($urandom_range(0, 99) < 70) ? 1'b1 :
                                 ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b1) &
                                 ($urandom_range(0, 1) == 1);
        end
    end

    // long receiver hold-off while the driver keeps offering
    initial begin
        wait (items_sent >= 300);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            1, 2: return CB'($urandom);
            default: return CB'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic push_vertex(logic signed [CB-1:0] qx, qy, qz, vx, vy, vz, bit f, bit l);
        vertex_item_t it;
        it.qx = qx; it.qy = qy; it.qz = qz;
        it.vx = vx; it.vy = vy; it.vz = vz;
        it.first = f;
        it.last = l;
        pending.push_back(it);
    endtask

    task automatic push_random_polyline();
        int n;
        logic signed [CB-1:0] q[3];
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 7);
        for (int k = 0; k < 3; k++) q[k] = rand_coord();
        for (int i = 0; i < n; i++)
            push_vertex(q[0], q[1], q[2], rand_coord(), rand_coord(), rand_coord(),
                        i == 0, i == n - 1);
    endtask

    initial begin
        model_reset();
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;

        // directed: one-vertex polyline, first and last together
        push_vertex(5, 5, 5, 1, 2, 3, 1, 1);
        // interior projection
        push_vertex(3, 7, -2, 0, 0, 0, 1, 0);
        push_vertex(3, 7, -2, 10, 0, 0, 0, 1);
        // zero-length segment, then segments whose projection falls before A
        push_vertex(-5, 0, 0, 4, 4, 4, 1, 0);
        push_vertex(0, 0, 0, 4, 4, 4, 0, 0);
        push_vertex(0, 0, 0, 20, 4, 4, 0, 0);
        push_vertex(0, 0, 0, 30, 4, 4, 0, 1);
        // equal distances: retraced segment keeps the earlier one
        push_vertex(5, 3, 0, 0, 0, 0, 1, 0);
        push_vertex(5, 3, 0, 10, 0, 0, 0, 0);
        push_vertex(5, 3, 0, 0, 0, 0, 0, 1);
        // stray vertices with no open polyline reuse the held query
        push_vertex(0, 0, 0, 9, 9, 9, 0, 0);
        push_vertex(0, 0, 0, -9, 1, 2, 0, 1);
        // coordinate extremes
        push_vertex(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                    24'sh800000, 24'sh7FFFFF, 24'sh800000, 1, 0);
        push_vertex(0, 0, 0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 0, 0);
        push_vertex(0, 0, 0, 24'sh800000, 24'sh800000, 24'sh800000, 0, 1);
        push_vertex(24'sh800000, 24'sh800000, 24'sh800000,
                    24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1, 0);
        push_vertex(0, 0, 0, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 0, 1);
        // restart a polyline in the middle of another
        push_vertex(1, 1, 1, 2, 2, 2, 1, 0);
        push_vertex(-1, -1, -1, 3, 3, 3, 1, 0);
        push_vertex(0, 0, 0, 6, 3, 3, 0, 1);

        while (pending.size() < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                push_vertex(rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(),
                            $urandom_range(0, 1), $urandom_range(0, 1));
            else
                push_random_polyline();
        end

        // saturation: degenerate segments keep this cheap
        for (int i = 0; i < MAXV + 4; i++)
            push_vertex(7, -7, 7, (i == 3) ? 24'sd100 : 24'sd50, 24'sd5, -24'sd5,
                        i == 0, i == MAXV + 3);
        push_random_polyline();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending.size() == 0 && !in_ch.valid && nearest_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (nearest_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, nearest_q.size());
            errors++;
        end
        $display("Run: %0d vertex items sent, %0d nearest results checked, %0d errors",
                 items_sent, results_seen, errors);
        $display("Covered degenerate and saturated polylines, extremes and a long output stall");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
